### hw/rtl/wrs_pkg.sv
package wrs_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int KEY_BITS    = 16;
  localparam int WEIGHT_BITS = 8;
  localparam int RND_BITS    = 31;

  localparam int IDX_W   = $clog2(MAX_ENTRIES);
  localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
  localparam int TOT_W   = $clog2(MAX_ENTRIES * ((1 << WEIGHT_BITS) - 1) + 1);
  localparam int RSTEP_W = $clog2(RND_BITS);

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_SETW   = 2'd2,
    ACT_SELECT = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_REPEAT     = 3'd1,
    ST_NOT_FOUND  = 3'd2,
    ST_FULL       = 3'd3,
    ST_ZERO_TOTAL = 3'd4
  } status_t;

endpackage

### hw/rtl/weighted_random_selector_no_repeat.sv
// channel   direction  handshake          fields
// request   in         start & !busy      action, key, weight, random_word
// result    out        done (one cycle)   status, chosen_key, chosen_index
//
// Add completes straight from idle. Set weight and remove scan the key memory,
// one entry per cycle; remove then moves later entries down at the same pace.
// Select scans the weights twice and, between the two scans, runs a remainder
// unit on the random word. Reset empties the table and forgets the last pick;
// the memories are not cleared. The result strobe cannot be held off by the
// receiver.
module weighted_random_selector_no_repeat
  import wrs_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic [1:0]             action,
  input  logic [KEY_BITS-1:0]    key,
  input  logic [WEIGHT_BITS-1:0] weight,
  input  logic [RND_BITS-1:0]    random_word,
  output logic                   done,
  output logic [2:0]             status,
  output logic [KEY_BITS-1:0]    chosen_key,
  output logic [IDX_W-1:0]       chosen_index
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_FIND  = 6'b000010,
    S_SHIFT = 6'b000100,
    S_SUM   = 6'b001000,
    S_DIV   = 6'b010000,
    S_PICK  = 6'b100000
  } state_t;

  state_t                 state;
  logic [CNT_W-1:0]       count;
  logic [IDX_W-1:0]       last_idx;
  logic                   last_vld;
  action_t                op;
  logic [KEY_BITS-1:0]    req_key;
  logic [WEIGHT_BITS-1:0] req_wt;
  logic [RND_BITS-1:0]    req_rnd;
  logic [CNT_W-1:0]       issue_idx;
  logic                   rd_vld;
  logic [IDX_W-1:0]       rd_tag;
  logic [TOT_W-1:0]       total;
  logic [TOT_W-1:0]       acc;
  logic [TOT_W-1:0]       target;

  logic                   accept;
  logic                   issue;
  logic                   hit;
  logic                   scan_end;
  logic [TOT_W-1:0]       acc_sum;
  logic [KEY_BITS-1:0]    rd_key;
  logic [WEIGHT_BITS-1:0] rd_wt;
  logic [IDX_W-1:0]       raddr;
  logic                   key_we;
  logic                   wt_we;
  logic [IDX_W-1:0]       waddr;
  logic [KEY_BITS-1:0]    wkey;
  logic [WEIGHT_BITS-1:0] wwt;
  logic                   div_start;
  logic                   div_done;
  logic [TOT_W-1:0]       div_rem;

  assign busy   = state != S_IDLE;
  assign accept = start && !busy;

  assign acc_sum = acc + TOT_W'(rd_wt);

  always_comb begin
    hit = 1'b0;
    if (rd_vld) begin
      if (state == S_FIND) begin
        hit = rd_key == req_key;
      end else if (state == S_PICK) begin
        hit = acc_sum >= target;
      end
    end
  end

  // stop issuing on a match so no stale read follows into the next state
  assign issue = (state inside {S_FIND, S_SHIFT, S_SUM, S_PICK}) &&
                 (issue_idx < count) && !hit;
  assign scan_end = !issue && !rd_vld;
  assign raddr    = issue_idx[IDX_W-1:0];

  assign div_start = (state == S_SUM) && scan_end && (total != '0);

  always_comb begin
    key_we = 1'b0;
    wt_we  = 1'b0;
    waddr  = count[IDX_W-1:0];
    wkey   = key;
    wwt    = weight;
    case (state)
      S_IDLE: begin
        if (accept && action == ACT_ADD && count < CNT_W'(MAX_ENTRIES)) begin
          key_we = 1'b1;
          wt_we  = 1'b1;
        end
      end
      S_FIND: begin
        if (hit && op == ACT_SETW) begin
          wt_we = 1'b1;
          waddr = rd_tag;
          wwt   = req_wt;
        end
      end
      S_SHIFT: begin
        if (rd_vld) begin
          key_we = 1'b1;
          wt_we  = 1'b1;
          waddr  = rd_tag - IDX_W'(1);
          wkey   = rd_key;
          wwt    = rd_wt;
        end
      end
      default: begin
      end
    endcase
  end

  wrs_ram #(.WIDTH(KEY_BITS), .DEPTH(MAX_ENTRIES)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (waddr),
    .wdata (wkey),
    .raddr (raddr),
    .rdata (rd_key)
  );

  wrs_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(MAX_ENTRIES)) u_wt_ram (
    .clk   (clk),
    .we    (wt_we),
    .waddr (waddr),
    .wdata (wwt),
    .raddr (raddr),
    .rdata (rd_wt)
  );

  wrs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (req_rnd),
    .divisor  (total),
    .done     (div_done),
    .rem      (div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      last_idx <= '0;
      last_vld <= 1'b0;
      rd_vld   <= 1'b0;
      done     <= 1'b0;
    end else begin
      done   <= 1'b0;
      rd_vld <= issue;
      rd_tag <= raddr;
      if (issue) begin
        issue_idx <= issue_idx + CNT_W'(1);
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            op        <= action_t'(action);
            req_key   <= key;
            req_wt    <= weight;
            req_rnd   <= random_word;
            issue_idx <= '0;
            total     <= '0;
            case (action_t'(action))
              ACT_ADD: begin
                done       <= 1'b1;
                chosen_key <= '0;
                if (count < CNT_W'(MAX_ENTRIES)) begin
                  status       <= ST_OK;
                  chosen_index <= count[IDX_W-1:0];
                  count        <= count + CNT_W'(1);
                end else begin
                  status       <= ST_FULL;
                  chosen_index <= '0;
                end
              end
              ACT_REMOVE: begin
                last_vld <= 1'b0;
                last_idx <= '0;
                state    <= S_FIND;
              end
              ACT_SETW: begin
                state <= S_FIND;
              end
              ACT_SELECT: begin
                state <= S_SUM;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_FIND: begin
          if (hit) begin
            if (op == ACT_REMOVE) begin
              // move entries above the match down by one
              issue_idx    <= {1'b0, rd_tag} + CNT_W'(1);
              chosen_index <= rd_tag;
              state        <= S_SHIFT;
            end else begin
              done         <= 1'b1;
              status       <= ST_OK;
              chosen_key   <= '0;
              chosen_index <= rd_tag;
              state        <= S_IDLE;
            end
          end else if (scan_end) begin
            done         <= 1'b1;
            status       <= ST_NOT_FOUND;
            chosen_key   <= '0;
            chosen_index <= '0;
            state        <= S_IDLE;
          end
        end
        S_SHIFT: begin
          if (scan_end) begin
            count      <= count - CNT_W'(1);
            done       <= 1'b1;
            status     <= ST_OK;
            chosen_key <= '0;
            state      <= S_IDLE;
          end
        end
        S_SUM: begin
          if (rd_vld) begin
            total <= total + TOT_W'(rd_wt);
          end
          if (scan_end) begin
            if (total == '0) begin
              done         <= 1'b1;
              status       <= ST_ZERO_TOTAL;
              chosen_key   <= '0;
              chosen_index <= '0;
              state        <= S_IDLE;
            end else begin
              state <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            target    <= div_rem + TOT_W'(1);
            acc       <= '0;
            issue_idx <= '0;
            state     <= S_PICK;
          end
        end
        S_PICK: begin
          if (hit) begin
            done         <= 1'b1;
            chosen_key   <= rd_key;
            chosen_index <= rd_tag;
            state        <= S_IDLE;
            if (last_vld && last_idx == rd_tag) begin
              status <= ST_REPEAT;
            end else begin
              status   <= ST_OK;
              last_idx <= rd_tag;
              last_vld <= 1'b1;
            end
          end else begin
            if (rd_vld) begin
              acc <= acc_sum;
            end
            if (scan_end) begin
              // cannot occur with a nonzero total; close the request anyway
              done         <= 1'b1;
              status       <= ST_ZERO_TOTAL;
              chosen_key   <= '0;
              chosen_index <= '0;
              state        <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### hw/rtl/wrs_ram.sv
module wrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/wrs_div.sv
module wrs_div
  import wrs_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [RND_BITS-1:0] dividend,
  input  logic [TOT_W-1:0]    divisor,
  output logic                done,
  output logic [TOT_W-1:0]    rem
);

  logic                run;
  logic [RSTEP_W-1:0]  step;
  logic [RND_BITS-1:0] dvd;
  logic [TOT_W-1:0]    dvs;
  logic [TOT_W:0]      shifted;
  logic                fits;

  // restoring remainder, one dividend bit per cycle
  assign shifted = {rem, dvd[RND_BITS-1]};
  assign fits    = shifted >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run  <= 1'b1;
        step <= '0;
        dvd  <= dividend;
        dvs  <= divisor;
        rem  <= '0;
      end else if (run) begin
        dvd <= {dvd[RND_BITS-2:0], 1'b0};
        if (fits) begin
          rem <= TOT_W'(shifted - {1'b0, dvs});
        end else begin
          rem <= shifted[TOT_W-1:0];
        end
        step <= step + RSTEP_W'(1);
        if (step == RSTEP_W'(RND_BITS - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
